@@ rtl/kws_pkg.sv @@
// ----------------------------------------------------------------------------
// kws_pkg
// shared types and constants for the keyword substitution cipher
// ----------------------------------------------------------------------------
package kws_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    localparam logic [4:0] LETTERS     = 5'd26;
    localparam logic [4:0] LAST_LETTER = 5'd25;
    localparam logic [7:0] LOW_A       = 8'h61;
    localparam logic [7:0] LOW_Z       = 8'h7A;

    localparam logic [1:0] QUEUE_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_KEY,
        OP_TEXT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] in_byte;
        logic       lower;
        logic [4:0] idx;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    typedef enum logic {
        ST_RUN,
        ST_FILL
    } t_bstate;

endpackage

@@ rtl/kws_front.sv @@
// ----------------------------------------------------------------------------
// kws_front
// accepts input words, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module kws_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_cmd,
    input  logic [7:0]     i_in_byte,
    output kws_pkg::t_q2b  o_q,
    input  logic           i_pop
);

    kws_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    kws_pkg::t_item n_item;
    logic           n_keep;
    logic [7:0]     n_diff;
    logic           push;
    logic           pop;

    always_comb begin
        n_diff         = i_in_byte - kws_pkg::LOW_A;
        n_item.in_byte = i_in_byte;
        n_item.lower   = i_in_byte inside {[kws_pkg::LOW_A:kws_pkg::LOW_Z]};
        n_item.idx     = n_diff[4:0];
        n_keep         = 1'b1;
        case (i_cmd)
            kws_pkg::CMD_CLEAR: n_item.op = kws_pkg::OP_CLEAR;
            kws_pkg::CMD_KEY:   n_item.op = kws_pkg::OP_KEY;
            kws_pkg::CMD_TEXT:  n_item.op = kws_pkg::OP_TEXT;
            default: begin
                // unused command has no effect, drop it here
                n_item.op = kws_pkg::OP_CLEAR;
                n_keep    = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == kws_pkg::QUEUE_FULL);
    assign push       = i_in_valid && !o_in_stall && n_keep;
    assign pop        = i_pop && (r_cnt != 2'd0);

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/kws_back.sv @@
// ----------------------------------------------------------------------------
// kws_back
// keyword table build, alphabet fill sweep, lookup and output register
// ----------------------------------------------------------------------------
module kws_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kws_pkg::t_q2b  i_q,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_substituted
);

    kws_pkg::t_bstate r_state;
    kws_pkg::t_bstate n_state;
    logic [4:0]       r_letter;
    logic [4:0]       n_letter;
    logic [7:0]       r_table [26];
    logic [4:0]       r_fill;
    logic             r_complete;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_subst;

    logic [7:0] fill_char;
    logic [7:0] seen_addr;
    logic       seen_rd;
    logic       can_out;
    logic       do_clear;
    logic       do_store;
    logic       do_emit;
    logic       set_complete;
    logic [7:0] store_byte;

    assign fill_char = kws_pkg::LOW_A + {3'b000, r_letter};
    assign seen_addr = (r_state == kws_pkg::ST_FILL) ? fill_char : i_q.item.in_byte;
    assign can_out   = !r_out_valid || !i_out_stall;

    // a byte counts as seen when it is among the stored entries; once all
    // 26 entries are stored nothing more is appended, so the check no longer matters
    always_comb begin
        seen_rd = 1'b0;
        for (int i = 0; i < int'(kws_pkg::LETTERS); i++) begin
            if ((5'(i) < r_fill) && (r_table[i] == seen_addr)) begin
                seen_rd = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kws_pkg::ST_RUN;
            r_letter <= 5'd0;
        end else begin
            r_state  <= n_state;
            r_letter <= n_letter;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_letter     = r_letter;
        o_pop        = 1'b0;
        do_clear     = 1'b0;
        do_store     = 1'b0;
        do_emit      = 1'b0;
        set_complete = 1'b0;
        store_byte   = i_q.item.in_byte;
        case (r_state)
            kws_pkg::ST_RUN: begin
                if (i_q.valid) begin
                    case (i_q.item.op)
                        kws_pkg::OP_CLEAR: begin
                            o_pop    = 1'b1;
                            do_clear = 1'b1;
                        end
                        kws_pkg::OP_KEY: begin
                            o_pop = 1'b1;
                            if (!r_complete && !seen_rd) begin
                                do_store = (r_fill < kws_pkg::LETTERS);
                            end
                        end
                        kws_pkg::OP_TEXT: begin
                            if (!r_complete) begin
                                // sweep 'z' down to 'a' before the first lookup
                                n_state  = kws_pkg::ST_FILL;
                                n_letter = kws_pkg::LAST_LETTER;
                            end else if (can_out) begin
                                o_pop   = 1'b1;
                                do_emit = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            kws_pkg::ST_FILL: begin
                store_byte = fill_char;
                do_store   = !seen_rd && (r_fill < kws_pkg::LETTERS);
                if (r_letter == 5'd0) begin
                    set_complete = 1'b1;
                    n_state      = kws_pkg::ST_RUN;
                end else begin
                    n_letter = r_letter - 5'd1;
                end
            end
            default: begin
                n_state = kws_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_table[r_fill] <= store_byte;
        end
        if (do_emit) begin
            r_out_byte <= i_q.item.lower ? r_table[i_q.item.idx] : i_q.item.in_byte;
            r_subst    <= i_q.item.lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 5'd0;
            r_complete  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_clear) begin
                r_fill     <= 5'd0;
                r_complete <= 1'b0;
            end else begin
                if (do_store) begin
                    r_fill <= r_fill + 5'd1;
                end
                if (set_complete) begin
                    r_complete <= 1'b1;
                end
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_substituted = r_subst;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= kws_pkg::LETTERS)
        else $error("fill count past table size");

    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kws_pkg::ST_FILL && r_letter == 5'd0)
        |=> (r_complete && r_fill == kws_pkg::LETTERS))
        else $error("table not full after sweep");

    a_emit_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_emit |-> (r_complete && r_state == kws_pkg::ST_RUN))
        else $error("lookup before table complete");

    a_no_pop_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kws_pkg::ST_FILL) |-> !o_pop)
        else $error("queue popped during sweep");

endmodule

@@ rtl/keyword_substitution_cipher.sv @@
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// builds a substitution alphabet from a keyword and enciphers text bytes
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | i_in_valid / o_in_stall | i_cmd, i_in_byte
//  output  | out       | o_out_valid / i_out_stall | o_out_byte, o_substituted
//
//  clear and keyword words are taken by the back end without waiting on the output
//  a text word is taken once the table is complete and the output register can take it
//  the first text word after a clear or reset waits while the back end sweeps
//  the alphabet from 'z' down to 'a' to complete the table
//  a two-word queue sits between the front and the back end
//  reset is synchronous; it clears the fill count, the complete flag and the queue
//  a stalled output holds its word while the queue takes input until it is full
module keyword_substitution_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_substituted
);

    kws_pkg::t_q2b q;
    logic          pop;

    kws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_in_byte  (i_in_byte),
        .o_q        (q),
        .i_pop      (pop)
    );

    kws_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (q),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_substituted (o_substituted)
    );

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keyword substitution cipher: directed words
// and random keyword/text sessions in turn; every accepted word is run
// through a local copy of the alphabet builder, and each output word is
// compared in order against the predicted cipher word
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // command code with no meaning, the block drops it
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       substituted;
    } t_cipher_out;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [1:0] in_cmd    = kws_pkg::CMD_CLEAR;
    logic [7:0] in_data   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_sub;

    // predicted alphabet state
    logic [7:0]   alpha_table [0:25];
    logic [255:0] seen_bytes  = '0;
    logic [4:0]   alpha_count = '0;
    logic         alpha_done  = 1'b0;
    t_cipher_out  cipher_out_due [$];

    bit calm       = 1'b0;
    int mismatches = 0;
    int cycle_count = 0;
    int hold_asks  = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    always #HALF_PERIOD clk = ~clk;

    keyword_substitution_cipher u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (in_cmd),
        .i_in_byte     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (out_byte),
        .o_substituted (out_sub)
    );

    function automatic void apply_cipher_word(input logic [1:0] op, input logic [7:0] data);
        t_cipher_out w;
        case (op)
            kws_pkg::CMD_CLEAR: begin
                seen_bytes  = '0;
                alpha_count = '0;
                alpha_done  = 1'b0;
            end
            kws_pkg::CMD_KEY: begin
                if (!alpha_done && !seen_bytes[data]) begin
                    seen_bytes[data] = 1'b1;
                    // past 26 entries the byte is only marked seen
                    if (alpha_count < kws_pkg::LETTERS) begin
                        alpha_table[alpha_count] = data;
                        alpha_count = alpha_count + 5'd1;
                    end
                end
            end
            kws_pkg::CMD_TEXT: begin
                if (!alpha_done) begin
                    for (int t = kws_pkg::LOW_Z; t >= kws_pkg::LOW_A; t--) begin
                        if (!seen_bytes[t] && alpha_count < kws_pkg::LETTERS) begin
                            alpha_table[alpha_count] = 8'(t);
                            alpha_count = alpha_count + 5'd1;
                        end
                    end
                    alpha_done = 1'b1;
                end
                if (data >= kws_pkg::LOW_A && data <= kws_pkg::LOW_Z) begin
                    w.out_byte    = alpha_table[data - kws_pkg::LOW_A];
                    w.substituted = 1'b1;
                end else begin
                    w.out_byte    = data;
                    w.substituted = 1'b0;
                end
                cipher_out_due.push_back(w);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte(input int lower_pct);
        if ($urandom_range(99) < lower_pct) begin
            return 8'($urandom_range(kws_pkg::LOW_Z, kws_pkg::LOW_A));
        end
        return 8'($urandom);
    endfunction

    // entered and left just after a falling edge
    task automatic send_word(input logic [1:0] op, input logic [7:0] data);
        while (!calm && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= op;
        in_data  <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_cipher_word(op, data);
        @(negedge clk);
    endtask

    // receiver: long hold-off on request, else random stall unless calm
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_taken) begin
            hold_taken <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 35);
        end
    end

    always @(posedge clk) begin
        t_cipher_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (cipher_out_due.size() == 0) begin
                $error("unexpected word: out_byte %h substituted %b", out_byte, out_sub);
                mismatches++;
            end else begin
                want = cipher_out_due.pop_front();
                if (out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h actual %h", want.out_byte, out_byte);
                    mismatches++;
                end
                if (out_sub !== want.substituted) begin
                    $error("substituted: expected %b actual %b", want.substituted, out_sub);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("keyword_substitution_cipher: mismatch");
            $finish;
        end
    end

    // no keyword since reset: reversed alphabet, plus the non-letter edges
    task automatic test_reset_alphabet();
        send_word(kws_pkg::CMD_TEXT, kws_pkg::LOW_A);
        send_word(kws_pkg::CMD_TEXT, kws_pkg::LOW_A + 8'd12);
        send_word(kws_pkg::CMD_TEXT, kws_pkg::LOW_Z);
        send_word(kws_pkg::CMD_TEXT, 8'h00);
        send_word(kws_pkg::CMD_TEXT, 8'hFF);
        send_word(kws_pkg::CMD_TEXT, kws_pkg::LOW_A - 8'd1);
        send_word(kws_pkg::CMD_TEXT, kws_pkg::LOW_Z + 8'd1);
    endtask

    // repeats dropped, zero and high bytes stored, late keyword ignored
    task automatic test_keyword_basics();
        send_word(kws_pkg::CMD_CLEAR, 8'hA5);
        send_word(kws_pkg::CMD_KEY, "k");
        send_word(kws_pkg::CMD_KEY, "e");
        send_word(kws_pkg::CMD_KEY, "y");
        send_word(kws_pkg::CMD_KEY, "k");
        send_word(kws_pkg::CMD_KEY, 8'h00);
        send_word(kws_pkg::CMD_KEY, 8'hFF);
        send_word(kws_pkg::CMD_TEXT, "a");
        send_word(kws_pkg::CMD_TEXT, "d");
        send_word(kws_pkg::CMD_TEXT, "f");
        send_word(kws_pkg::CMD_TEXT, kws_pkg::LOW_Z);
        send_word(kws_pkg::CMD_TEXT, 8'h41);
        send_word(kws_pkg::CMD_KEY, "q");
        send_word(CMD_SPARE, 8'h5A);
        send_word(kws_pkg::CMD_TEXT, "e");
    endtask

    // more than 26 distinct keyword bytes, then every letter
    task automatic test_keyword_overflow();
        logic [7:0] base;
        base = 8'($urandom);
        send_word(kws_pkg::CMD_CLEAR, 8'($urandom));
        for (int i = 0; i < 30; i++) begin
            send_word(kws_pkg::CMD_KEY, base + 8'(7 * i));
        end
        for (int i = 0; i < 26; i++) begin
            send_word(kws_pkg::CMD_TEXT, kws_pkg::LOW_A + 8'(i));
        end
        send_word(kws_pkg::CMD_TEXT, pick_byte(0));
    endtask

    task automatic run_sessions(input int target);
        int  n;
        int  klen;
        int  tlen;
        bit  wide;
        n = 0;
        while (n < target) begin
            // now and then skip the clear so the keyword lands after text
            if ($urandom_range(7) != 0) begin
                send_word(kws_pkg::CMD_CLEAR, 8'($urandom));
                n++;
            end
            wide = ($urandom_range(5) == 0);
            klen = wide ? $urandom_range(40, 27) : $urandom_range(12, 0);
            repeat (klen) begin
                send_word(kws_pkg::CMD_KEY, wide ? 8'($urandom) : pick_byte(70));
                n++;
            end
            tlen = $urandom_range(25, 1);
            repeat (tlen) begin
                send_word(kws_pkg::CMD_TEXT, pick_byte(75));
                n++;
                if ($urandom_range(19) == 0) begin
                    send_word(kws_pkg::CMD_KEY, pick_byte(50));
                    n++;
                end
                if ($urandom_range(29) == 0) begin
                    send_word(CMD_SPARE, 8'($urandom));
                    n++;
                end
            end
        end
    endtask

    // output held off for a long time while text keeps coming
    task automatic test_backpressure();
        send_word(kws_pkg::CMD_CLEAR, 8'($urandom));
        send_word(kws_pkg::CMD_KEY, pick_byte(80));
        hold_asks++;
        repeat (24) send_word(kws_pkg::CMD_TEXT, pick_byte(75));
    endtask

    task automatic test_calm_stream();
        calm = 1'b1;
        run_sessions(400);
        calm = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_alphabet();
        test_keyword_basics();
        run_sessions(650);
        test_keyword_overflow();
        test_backpressure();
        test_calm_stream();
        run_sessions(550);
        in_valid <= 1'b0;
        while (cipher_out_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("keyword_substitution_cipher: match");
        end else begin
            $display("keyword_substitution_cipher: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/kws_pkg.sv
rtl/kws_front.sv
rtl/kws_back.sv
rtl/keyword_substitution_cipher.sv
verif/tb_top.sv
